// ===== rtl/core/bba_pkg.sv =====
// Shared constants and types of the bitmap block allocator.
`default_nettype none
package bba_pkg;

    localparam int BBA_MAX_BLOCKS_DEF = 1024;
    localparam int WORD_BITS          = 32;
    localparam int WORD_SH            = 5;
    localparam int CFG_W              = 11;
    localparam int IDX_W              = 10;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    typedef struct packed {
        logic               hit;
        logic [WORD_SH-1:0] first;
        logic               sel_bit;
    } bba_scan_t;

endpackage
`default_nettype wire

// ===== rtl/core/bba_bitmap_ram.sv =====
// Word-wide free map store: one write port, one registered read port.
`default_nettype none
module bba_bitmap_ram #(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [bba_pkg::WORD_BITS-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [bba_pkg::WORD_BITS-1:0] wr_data
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bba_word_unit.sv =====
// Shared word unit: limit mask, lowest free bit search and single bit pick.
`default_nettype none
module bba_word_unit (
    input  wire logic [bba_pkg::WORD_BITS-1:0] word,
    input  wire logic [bba_pkg::WORD_SH:0]     lim,
    input  wire logic [bba_pkg::WORD_SH-1:0]   bit_sel,
    output bba_pkg::bba_scan_t                 scan
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] masked;

    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            masked[k] = word[k] && ((WORD_SH + 1)'(k) < lim);
        end
    end

    // priority encode, lowest set bit wins
    always_comb
    begin
        scan.hit     = |masked;
        scan.first   = '0;
        scan.sel_bit = word[bit_sel];
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (masked[k])
            begin
                scan.first = WORD_SH'(k);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_block_allocator_core.sv =====
// Top level of the bitmap first-fit block allocator.
`default_nettype none
// Bitmap first-fit block allocator. One free/used mark per block is kept in
// a word-wide store of 32-bit words. Each request on the slave stream carries
// an operation (allocate, release, mark used, query) and a block index, and
// produces exactly one response on the master stream. Allocate scans the
// store one word per cycle from word 0 through a single shared word unit and
// takes the lowest free block below the managed count (blocks_in_use clamped
// to MAX_BLOCKS). After reset the store is cleared to all free, word by word,
// and no request is taken while it is cleared. Release, mark and query go
// through a read, an update and a response; an out of range index goes
// straight to the response. Allocate reads one word after another until a
// free block is found, at most ceil(count/32) words (32 words for 1024
// blocks), and one word for a count of zero; the single read port of the
// store allows no more than one word at a time. One request is in flight at
// a time; a finished response waits in the output register, and the next
// request may be taken while it waits. The user must write the configuration
// register through cfg_wr_en and cfg_wr_data while the block is idle; the
// block itself does not enforce this. A write leaves the map untouched.
module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration: blocks_in_use
    input  wire logic                      cfg_wr_en,
    input  wire logic [bba_pkg::CFG_W-1:0] cfg_wr_data,
    // request stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,  // func[1:0], block_index[11:2]
    // response stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [15:0]               m_tdata   // status[1:0], result_index[11:2],
                                                     // is_free[12]
);
    import bba_pkg::*;

    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = AW + WORD_SH;
    localparam int CNT_W = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // unpack the request
    logic [1:0]       in_func;
    logic [IDX_W-1:0] in_index;
    assign in_func  = s_tdata[1:0];
    assign in_index = s_tdata[11:2];

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      chk_reg, chk_next;       // word under work, or clear pointer
    logic [1:0]         func_reg, func_next;
    logic [WORD_SH-1:0] bit_reg, bit_next;
    logic [CFG_W-1:0]   cfg_reg;

    logic [1:0]         res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_index_reg, res_index_next;
    logic               res_free_reg, res_free_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [1:0]         m_status_reg;
    logic [IDX_W-1:0]   m_index_reg;
    logic               m_free_reg;
    logic               m_load;

    // store port
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] rd_data, wr_data;

    // shared word unit
    logic [WORD_SH:0]     lim;
    bba_scan_t            scan;

    // managed count, clamped to MAX_BLOCKS
    logic [CNT_W-1:0] cfg_ext, n_cnt, base_c, rem, idx_c;
    logic [XW-1:0]    base_s, idx_x;
    logic [WORD_BITS-1:0] onehot;

    assign cfg_ext = CNT_W'(cfg_reg);
    assign n_cnt   = (cfg_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_ext;
    assign base_s  = {chk_reg, {WORD_SH{1'b0}}};
    assign base_c  = CNT_W'(base_s);
    assign rem     = (n_cnt > base_c) ? (n_cnt - base_c) : '0;
    assign lim     = (rem >= CNT_W'(WORD_BITS)) ? (WORD_SH + 1)'(WORD_BITS)
                                                : rem[WORD_SH:0];
    assign idx_x   = XW'(in_index);
    assign idx_c   = CNT_W'(in_index);

    bba_bitmap_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bba_word_unit u_unit (
        .word    (rd_data),
        .lim     (lim),
        .bit_sel (bit_reg),
        .scan    (scan)
    );

    // bit mask for the selected block inside its word
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            onehot = WORD_BITS'(1) << scan.first;
        end
        else
        begin
            onehot = WORD_BITS'(1) << bit_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_load   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        chk_next        = chk_reg;
        func_next       = func_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_free_next   = res_free_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = chk_reg;
        wr_data         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the store to all free
                wr_en   = 1'b1;
                wr_data = '1;
                if (chk_reg == AW'(WORDS - 1))
                begin
                    chk_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next       = in_func;
                    bit_next        = idx_x[WORD_SH-1:0];
                    res_status_next = ST_OK;
                    res_index_next  = '0;
                    res_free_next   = 1'b0;
                    if (in_func == OP_ALLOC)
                    begin
                        // start the scan at word 0
                        chk_next   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                    else if (idx_c >= n_cnt)
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        chk_next   = idx_x[XW-1:WORD_SH];
                        rd_en      = 1'b1;
                        rd_addr    = idx_x[XW-1:WORD_SH];
                        state_next = S_BIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan.hit)
                begin
                    // take the lowest free block and mark it used
                    wr_en           = 1'b1;
                    wr_data         = rd_data & ~onehot;
                    res_status_next = ST_OK;
                    res_index_next  = IDX_W'(base_c + CNT_W'(scan.first));
                    state_next      = S_DONE;
                end
                else if (base_c + CNT_W'(WORD_BITS) >= n_cnt)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    // advance to the next word
                    chk_next = chk_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = chk_reg + 1'b1;
                end
            end
            S_BIT:
            begin
                unique case (func_reg)
                    OP_RELEASE:
                    begin
                        if (scan.sel_bit)
                        begin
                            res_status_next = ST_ALREADY;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data | onehot;
                        end
                    end
                    OP_MARK:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~onehot;
                    end
                    OP_QUERY:
                    begin
                        res_free_next = scan.sel_bit;
                    end
                    OP_ALLOC:
                    begin
                        // handled in the scan state
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (m_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            chk_reg      <= '0;
            cfg_reg      <= CFG_W'(1024);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_reg      <= chk_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_free_reg   <= res_free_next;
        if (m_load)
        begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_free_reg   <= res_free_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_free_reg, m_index_reg, m_status_reg};

endmodule
`default_nettype wire
